@@ src/vftf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vftf_pkg
// Shared types, constants and handshake structs for the value frequency
// threshold finder.
// ----------------------------------------------------------------------------
package vftf_pkg;

   localparam int VALUE_BITS = 12;
   localparam int COUNT_BITS = 3;
   localparam int FIELD_VALUE_W = 12;
   localparam int TOTAL_W = 13;
   localparam int MIN_OCC_W = 3;
   localparam int CMP_BITS = (COUNT_BITS > MIN_OCC_W) ? COUNT_BITS : MIN_OCC_W;

   typedef logic [VALUE_BITS-1:0] idx_type;
   typedef logic [VALUE_BITS:0] addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CMP_BITS-1:0] cmp_type;
   typedef logic [MIN_OCC_W-1:0] min_occ_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [FIELD_VALUE_W-1:0] field_value_type;

   localparam count_type COUNT_MAX = count_type'((1 << COUNT_BITS) - 1);
   localparam min_occ_type MIN_OCC_RESET = min_occ_type'(2);

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_FIND  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef struct packed {
      func_type        func;
      field_value_type value;
   } req_type;

   typedef struct packed {
      total_type       qualified_total;
      logic            found;
      field_value_type found_value;
   } rsp_type;

   typedef struct packed {
      logic accept;       // latch item, seed address
      logic clear_total;
      logic sweep_wr;     // write zero at address, advance
      logic add_rd;
      logic add_wr;
      logic scan;         // issue find read, check previous
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic addr_end;
      logic hit;
      logic scan_end;
   } sts_type;

endpackage
`default_nettype wire

@@ src/vftf_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vftf_datapath
// Count store, sweep address counter, find check stage, running total,
// threshold register and result register.
// ----------------------------------------------------------------------------
module vftf_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire vftf_pkg::req_type      req_data,
   input  wire logic                   csr_we,
   input  wire vftf_pkg::min_occ_type  csr_data,
   input  wire vftf_pkg::cmd_type      cmd,
   output vftf_pkg::sts_type           sts,
   output vftf_pkg::rsp_type           rsp_data
);

   vftf_pkg::count_type   mem [vftf_pkg::VALUE_BITS'(0):(1 << vftf_pkg::VALUE_BITS) - 1];

   vftf_pkg::func_type    func_ff;
   vftf_pkg::idx_type     item_ff;
   vftf_pkg::addr_type    addr_ff, addr_in;
   vftf_pkg::count_type   rd_ff;
   logic                  chk_valid_ff;
   vftf_pkg::idx_type     chk_addr_ff;
   logic                  found_ff;
   vftf_pkg::idx_type     found_value_ff;
   vftf_pkg::total_type   total_ff, total_in;
   vftf_pkg::min_occ_type min_occ_ff;
   vftf_pkg::rsp_type     rsp_ff;

   vftf_pkg::min_occ_type thr;
   vftf_pkg::idx_type     req_idx;
   vftf_pkg::idx_type     addr_idx;
   vftf_pkg::count_type   new_count;
   logic                  mem_we, mem_re;
   vftf_pkg::idx_type     wr_addr, rd_addr;
   vftf_pkg::count_type   wr_data;
   logic                  crosses;

   // zero threshold behaves as one
   assign thr = (min_occ_ff == '0) ? vftf_pkg::min_occ_type'(1) : min_occ_ff;

   assign req_idx  = vftf_pkg::idx_type'(req_data.value);
   assign addr_idx = addr_ff[vftf_pkg::VALUE_BITS-1:0];

   assign sts.addr_end = addr_ff[vftf_pkg::VALUE_BITS];
   assign sts.hit      = chk_valid_ff
                         && (vftf_pkg::cmp_type'(rd_ff) >= vftf_pkg::cmp_type'(thr));
   assign sts.scan_end = addr_ff[vftf_pkg::VALUE_BITS] && !chk_valid_ff;

   assign new_count = rd_ff + vftf_pkg::count_type'(1);
   assign crosses   = (vftf_pkg::cmp_type'(rd_ff) < vftf_pkg::cmp_type'(thr))
                      && (vftf_pkg::cmp_type'(new_count) >= vftf_pkg::cmp_type'(thr));

   assign mem_we  = (cmd.add_wr && (rd_ff != vftf_pkg::COUNT_MAX))
                    || (cmd.sweep_wr && !addr_ff[vftf_pkg::VALUE_BITS]);
   assign wr_addr = cmd.add_wr ? item_ff : addr_idx;
   assign wr_data = cmd.add_wr ? new_count : '0;
   assign mem_re  = cmd.add_rd || (cmd.scan && !addr_ff[vftf_pkg::VALUE_BITS]);
   assign rd_addr = cmd.add_rd ? item_ff : addr_idx;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.accept) begin
         addr_in = (req_data.func == vftf_pkg::FUNC_FIND)
                   ? {1'b0, req_idx} : '0;
      end else if ((cmd.sweep_wr || cmd.scan) && !addr_ff[vftf_pkg::VALUE_BITS]) begin
         addr_in = addr_ff + vftf_pkg::addr_type'(1);
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.clear_total) begin
         total_in = '0;
      end else if (cmd.add_wr && (rd_ff != vftf_pkg::COUNT_MAX) && crosses) begin
         total_in = total_ff + vftf_pkg::total_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         total_ff     <= '0;
         min_occ_ff   <= vftf_pkg::MIN_OCC_RESET;
         chk_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         total_ff     <= total_in;
         chk_valid_ff <= cmd.scan && !addr_ff[vftf_pkg::VALUE_BITS];
         if (csr_we) begin
            min_occ_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= addr_idx;
      if (cmd.accept) begin
         func_ff        <= req_data.func;
         item_ff        <= req_idx;
         found_ff       <= 1'b0;
         found_value_ff <= '0;
      end else if (cmd.scan && sts.hit && func_ff == vftf_pkg::FUNC_FIND) begin
         found_ff       <= 1'b1;
         found_value_ff <= chk_addr_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff.qualified_total <= total_in;
         rsp_ff.found           <= found_ff;
         rsp_ff.found_value     <= vftf_pkg::field_value_type'(found_value_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

@@ src/vftf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vftf_ctrl
// Sequencer: power-up clearing sweep, one item at a time, result handshake.
// ----------------------------------------------------------------------------
module vftf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire vftf_pkg::func_type req_func,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire vftf_pkg::sts_type  sts,
   output vftf_pkg::cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_ADD_RD = 7'b0000100,
      S_ADD_WR = 7'b0001000,
      S_FIND   = 7'b0010000,
      S_CLEAR  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_wr = 1'b1;
            if (sts.addr_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept      = 1'b1;
               cmd.clear_total = (req_func == vftf_pkg::FUNC_CLEAR);
               unique case (req_func)
                  vftf_pkg::FUNC_ADD:   state_in = S_ADD_RD;
                  vftf_pkg::FUNC_FIND:  state_in = S_FIND;
                  vftf_pkg::FUNC_CLEAR: state_in = S_CLEAR;
                  vftf_pkg::FUNC_NONE:  state_in = S_FINISH;
               endcase
            end
         end
         S_ADD_RD: begin
            cmd.add_rd = 1'b1;
            state_in   = S_ADD_WR;
         end
         S_ADD_WR: begin
            // write-back held until the result register can take the transfer
            if (out_free) begin
               cmd.add_wr   = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIND: begin
            cmd.scan = 1'b1;
            if (sts.hit || sts.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (sts.addr_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ src/value_frequency_threshold_finder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// value_frequency_threshold_finder
// Occurrence histogram over 12-bit values with threshold total and
// ascending find of qualifying values.
//
//   channel  ports                                  direction
//   req      req_valid  req_ready  req_data         in  (func, value)
//   rsp      rsp_valid  rsp_ready  rsp_data         out (total, found, value)
//   csr      csr_valid  csr_ready  csr_data         in  (min_occurrences)
//
// add does one count store read, then one write unless the count is saturated
// find reads the store from the requested value upward, one position per
// cycle, and stops at the first qualifying value or after the top position
// clear zeroes the total and every store entry, one per cycle; unused func 3
// after reset a clearing sweep runs with req_ready low
// one item in flight; req_ready returns once the result sits in the output
// register, a stalled rsp only holds the final step of the next item
// ----------------------------------------------------------------------------
module value_frequency_threshold_finder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire vftf_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output vftf_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire vftf_pkg::min_occ_type csr_data
);

   vftf_pkg::cmd_type cmd;
   vftf_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   vftf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vftf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
